>>> sv/srer_pkg.sv
// Package for the serial receive escape router.
// Types, byte codes and default sizes shared by the router files other than srer_if; no dependencies.
`default_nettype none
package srer_pkg;

   localparam int CLIENT_COUNT_DEF = 8;
   localparam int FIFO_DEPTH_DEF   = 2;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_AT     = 8'h40;
   localparam logic [7:0] CHAR_M      = 8'h6D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   typedef enum logic [1:0] {
      ESC_NORMAL  = 2'd0,
      ESC_ESCAPED = 2'd1,
      ESC_AT      = 2'd2
   } esc_type;

   typedef enum logic {
      CMD_DELIVER = 1'b0,
      CMD_REQUEST = 1'b1
   } cmd_kind_type;

   typedef enum logic {
      BACK_IDLE  = 1'b0,
      BACK_BCAST = 1'b1
   } back_state_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         bcast;
      logic [3:0]   client;
      logic [7:0]   data;
      logic [7:0]   mask;
   } cmd_type;

endpackage
`default_nettype wire

>>> sv/srer_if.sv
// Handshake channels of the router: request words in, delivery words out.
// Depends on nothing.
`default_nettype none
interface srer_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic [3:0] channel;
   logic [7:0] free_mask;
   modport source (output valid, operation, data_byte, channel, free_mask, input ready);
   modport sink   (input valid, operation, data_byte, channel, free_mask, output ready);
endinterface

interface srer_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] dest_client;
   logic [7:0] out_byte;
   logic       notify;
   logic       last;
   modport source (output valid, dest_client, out_byte, notify, last, input ready);
   modport sink   (input valid, dest_client, out_byte, notify, last, output ready);
endinterface
`default_nettype wire

>>> sv/srer_front.sv
// Front end: escape decode, client select and command generation.
// Depends on srer_pkg and srer_req_if.
`default_nettype none
module srer_front #(
   parameter int CLIENT_COUNT = srer_pkg::CLIENT_COUNT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   srer_req_if.sink        req_if,
   output srer_pkg::cmd_type push_cmd,
   output logic            push_valid,
   input  wire logic       push_ready
);

   srer_pkg::esc_type esc_ff, esc_in;
   logic [3:0]        client_ff, client_in;
   logic              bcast_ff, bcast_in;
   logic              accept, want_push;
   logic [7:0]        digit;

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && push_ready;
   assign push_valid   = accept && want_push;

   always_comb begin
      esc_in          = esc_ff;
      client_in       = client_ff;
      bcast_in        = bcast_ff;
      want_push       = 1'b0;
      digit           = req_if.data_byte - srer_pkg::CHAR_ZERO;
      push_cmd.kind   = srer_pkg::CMD_DELIVER;
      push_cmd.bcast  = bcast_ff;
      push_cmd.client = client_ff;
      push_cmd.data   = req_if.data_byte;
      push_cmd.mask   = req_if.free_mask;
      if (req_if.operation) begin
         push_cmd.kind   = srer_pkg::CMD_REQUEST;
         push_cmd.client = req_if.channel;
         want_push = (req_if.channel != 4'd0) && (int'(req_if.channel) <= CLIENT_COUNT);
      end else begin
         case (esc_ff)
            srer_pkg::ESC_NORMAL: begin
               if (req_if.data_byte == srer_pkg::CHAR_BSLASH) begin
                  esc_in = srer_pkg::ESC_ESCAPED;
               end else if (req_if.data_byte == srer_pkg::CHAR_AT) begin
                  esc_in = srer_pkg::ESC_AT;
               end else begin
                  want_push = 1'b1;
               end
            end
            srer_pkg::ESC_ESCAPED: begin
               esc_in    = srer_pkg::ESC_NORMAL;
               want_push = 1'b1;
            end
            srer_pkg::ESC_AT: begin
               esc_in = srer_pkg::ESC_NORMAL;
               if (req_if.data_byte == srer_pkg::CHAR_M) begin
                  bcast_in  = 1'b1;
                  client_in = 4'd0;
               end else begin
                  bcast_in = 1'b0;
                  if (digit != 8'd0 && int'(digit) <= CLIENT_COUNT) begin
                     client_in = digit[3:0];
                  end
               end
            end
            default: begin
               esc_in = srer_pkg::ESC_NORMAL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff    <= srer_pkg::ESC_NORMAL;
         client_ff <= 4'd1;
         bcast_ff  <= 1'b0;
      end else if (accept) begin
         esc_ff    <= esc_in;
         client_ff <= client_in;
         bcast_ff  <= bcast_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/srer_fifo.sv
// Short command queue between the front end and the delivery engine.
// Depends on srer_pkg.
`default_nettype none
module srer_fifo #(
   parameter int DEPTH = srer_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire srer_pkg::cmd_type push_cmd,
   input  wire logic              push_valid,
   output logic                   push_ready,
   output srer_pkg::cmd_type      pop_cmd,
   output logic                   pop_valid,
   input  wire logic              pop_ready
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   srer_pkg::cmd_type mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> sv/srer_back.sv
// Delivery engine: request credits, single-client and broadcast delivery,
// output register. Depends on srer_pkg and srer_rsp_if.
`default_nettype none
module srer_back #(
   parameter int CLIENT_COUNT = srer_pkg::CLIENT_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire srer_pkg::cmd_type pop_cmd,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   srer_rsp_if.source             rsp_if
);

   localparam int EW = CLIENT_COUNT + 8;

   srer_pkg::back_state_type state_ff, state_in;
   logic [7:0]              credit_ff [CLIENT_COUNT];
   logic [7:0]              credit_in [CLIENT_COUNT];
   logic [CLIENT_COUNT-1:0] pos_ff, pos_in;
   logic [3:0]              idx_ff, idx_in;
   logic [7:0]              data_ff, data_in, mask_ff, mask_in;
   logic                    valid_ff, valid_in;
   logic [3:0]              dest_ff, dest_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    notify_ff, notify_in, last_ff, last_in;
   logic [EW-1:0]           cmd_ext, hold_ext;
   logic [CLIENT_COUNT-1:0] cmd_free, hold_free, client_oh, ok_vec;
   logic                    out_free, ok_cur, ok_next;

   assign cmd_ext   = {{CLIENT_COUNT{1'b0}}, pop_cmd.mask};
   assign hold_ext  = {{CLIENT_COUNT{1'b0}}, mask_ff};
   assign cmd_free  = cmd_ext[CLIENT_COUNT-1:0];
   assign hold_free = hold_ext[CLIENT_COUNT-1:0];
   assign out_free  = !valid_ff || rsp_if.ready;
   assign pop_ready = (state_ff == srer_pkg::BACK_IDLE) && out_free;
   assign ok_cur    = |(ok_vec & pos_ff);
   assign ok_next   = |(ok_vec & (pos_ff << 1));

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.dest_client = dest_ff;
   assign rsp_if.out_byte    = byte_ff;
   assign rsp_if.notify      = notify_ff;
   assign rsp_if.last        = last_ff;

   always_comb begin
      for (int i = 0; i < CLIENT_COUNT; i++) begin
         ok_vec[i]    = (credit_ff[i] != 8'd0) && hold_free[i];
         client_oh[i] = (pop_cmd.client == 4'(i + 1));
      end
   end

   always_comb begin
      state_in  = state_ff;
      credit_in = credit_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      data_in   = data_ff;
      mask_in   = mask_ff;
      valid_in  = valid_ff && !rsp_if.ready;
      dest_in   = dest_ff;
      byte_in   = byte_ff;
      notify_in = notify_ff;
      last_in   = last_ff;
      case (state_ff)
         srer_pkg::BACK_IDLE: begin
            if (pop_valid && out_free) begin
               if (pop_cmd.kind == srer_pkg::CMD_REQUEST) begin
                  for (int i = 0; i < CLIENT_COUNT; i++) begin
                     if (client_oh[i] && credit_ff[i] != 8'hFF) begin
                        credit_in[i] = credit_ff[i] + 8'd1;
                     end
                  end
               end else if (pop_cmd.bcast) begin
                  state_in  = srer_pkg::BACK_BCAST;
                  pos_in    = '0;
                  pos_in[0] = 1'b1;
                  idx_in    = 4'd1;
                  data_in   = pop_cmd.data;
                  mask_in   = pop_cmd.mask;
               end else if (|(cmd_free & client_oh)) begin
                  valid_in  = 1'b1;
                  dest_in   = pop_cmd.client;
                  byte_in   = pop_cmd.data;
                  notify_in = 1'b1;
                  last_in   = 1'b1;
               end
            end
         end
         srer_pkg::BACK_BCAST: begin
            if (out_free) begin
               if (ok_cur) begin
                  valid_in  = 1'b1;
                  dest_in   = idx_ff;
                  byte_in   = data_ff;
                  notify_in = 1'b0;
                  last_in   = !ok_next;
                  for (int i = 0; i < CLIENT_COUNT; i++) begin
                     if (pos_ff[i]) begin
                        credit_in[i] = credit_ff[i] - 8'd1;
                     end
                  end
                  pos_in = pos_ff << 1;
                  idx_in = idx_ff + 4'd1;
                  if (!ok_next) begin
                     state_in = srer_pkg::BACK_IDLE;
                  end
               end else begin
                  state_in = srer_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = srer_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srer_pkg::BACK_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < CLIENT_COUNT; i++) begin
            credit_ff[i] <= 8'd0;
         end
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      data_ff   <= data_in;
      mask_ff   <= mask_in;
      dest_ff   <= dest_in;
      byte_ff   <= byte_in;
      notify_ff <= notify_in;
      last_ff   <= last_in;
   end

endmodule
`default_nettype wire

>>> sv/serial_rx_escape_router_core.sv
// Serial receive escape router, top level. Depends on srer_pkg, srer_if,
// srer_front, srer_fifo and srer_back.
// Path: a single-client word passes through the command queue and the output register; a
// broadcast byte also passes through the broadcast state before its first result.
// Throughput: one request word per cycle into the command queue while the queue is not full;
// the delivery engine takes one command per cycle while it is idle and its output register is
// free, and takes no new command while it delivers a broadcast byte.
// Reset (synchronous): escape normal, client 1, broadcast off, credits zero, queue empty.
`default_nettype none
module serial_rx_escape_router_core #(
   parameter int CLIENT_COUNT = srer_pkg::CLIENT_COUNT_DEF,
   parameter int FIFO_DEPTH   = srer_pkg::FIFO_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srer_req_if.sink   req_if,
   srer_rsp_if.source rsp_if
);

   srer_pkg::cmd_type push_cmd, pop_cmd;
   logic              push_valid, push_ready, pop_valid, pop_ready;

   srer_front #(.CLIENT_COUNT(CLIENT_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   srer_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   srer_back #(.CLIENT_COUNT(CLIENT_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_cmd   (pop_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire
